FILE: src/rsakg_pkg.sv
// Package for the small-prime RSA key generator.
// Holds status codes, widths and the divider request and response types; no dependencies.
package rsakg_pkg;
  localparam int PrimeW = 16;
  localparam int WordW  = 32;
  localparam int WideW  = 64;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NON_PRIME = 2'd1,
    ST_EXP_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    logic             start;
    logic [WideW-1:0] dividend;
    logic [WordW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [WideW-1:0] quotient;
    logic [WordW-1:0] remainder;
  } div_rsp_t;
endpackage

FILE: src/rsakg_div.sv
// Shared radix-2 restoring divider: 64-bit dividend by 32-bit divisor.
// Depends on rsakg_pkg. One quotient bit per cycle.
module rsakg_div import rsakg_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);
  logic [WideW-1:0] quo_r, quo_nxt;
  logic [WordW-1:0] rem_r, rem_nxt;
  logic [WordW-1:0] dvs_r, dvs_nxt;
  logic [6:0]       cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt, done_r, done_nxt;
  logic [WordW+1:0] trial;
  logic [WordW:0]   shifted;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r, quo_r[WideW-1]};
    trial    = {1'b0, shifted} - {2'b00, dvs_r};
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      cnt_nxt  = 7'(WideW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // The partial remainder always stays below the divisor, so 32 bits hold it.
      if (!trial[WordW+1]) begin
        rem_nxt = trial[WordW-1:0];
        quo_nxt = {quo_r[WideW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[WordW-1:0];
        quo_nxt = {quo_r[WideW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;
endmodule

FILE: src/rsa_key_generation.sv
// Top level of the small-prime RSA key generator.
// Depends on rsakg_pkg and rsakg_div.
//
// One beat in (two 16-bit candidates) gives one beat out. All dividing goes
// through one shared bit-serial divider, and the block takes no new beat
// until the result beat has been taken. Cost: trial division takes up to
// about 255 divisions per candidate, the exponent search one Euclid run per
// tried exponent (each a handful of divisions), and the inverse search one
// division per tried k, the last of which also gives the private exponent.
// Products are formed by combinational 32x32 multipliers.
module rsa_key_generation import rsakg_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // prime_a [15:0], prime_b [31:16]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata   // modulus, totient, public_exp, private_exp, status
);
  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_TD     = 11'b00000000010,  // trial division test of d*d <= v
    S_TDW    = 11'b00000000100,
    S_MUL    = 11'b00000001000,
    S_GCD    = 11'b00000010000,  // start Euclid step
    S_GCDW   = 11'b00000100000,
    S_CHK    = 11'b00001000000,
    S_INV    = 11'b00010000000,
    S_INVW   = 11'b00100000000,
    S_FIN    = 11'b01000000000,
    S_OUT    = 11'b10000000000
  } state_t;

  state_t           st_r, st_nxt;
  logic [PrimeW-1:0] pa_r, pb_r, pa_nxt, pb_nxt, v_r, v_nxt;
  logic             sel_r, sel_nxt;
  logic [PrimeW:0]  d_r, d_nxt;
  logic [WordW-1:0] mod_r, tot_r, e_r, ga_r, gb_r, k_r, pe_r;
  logic [WordW-1:0] mod_nxt, tot_nxt, e_nxt, ga_nxt, gb_nxt, k_nxt, pe_nxt;
  status_t          stat_r, stat_nxt;
  div_req_t         req;
  div_rsp_t         rsp;
  logic [33:0]      dsq;
  logic [WideW-1:0] kt1;

  rsakg_div u_div (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

  assign dsq = {17'd0, d_r} * {17'd0, d_r};
  assign kt1 = {32'd0, k_r} * {32'd0, tot_r} + 64'd1;

  always_comb begin
    st_nxt = st_r; pa_nxt = pa_r; pb_nxt = pb_r; v_nxt = v_r; sel_nxt = sel_r;
    d_nxt = d_r; mod_nxt = mod_r; tot_nxt = tot_r; e_nxt = e_r; ga_nxt = ga_r;
    gb_nxt = gb_r; k_nxt = k_r; pe_nxt = pe_r; stat_nxt = stat_r;
    req = '0;
    unique case (st_r)
      S_IDLE: if (in_tvalid) begin
        pa_nxt = in_tdata[15:0]; pb_nxt = in_tdata[31:16];
        v_nxt = in_tdata[15:0]; sel_nxt = 1'b0; d_nxt = 17'd2;
        mod_nxt = '0; tot_nxt = '0; e_nxt = '0; pe_nxt = '0;
        if (in_tdata[15:0] < 16'd2) begin
          stat_nxt = ST_NON_PRIME; st_nxt = S_OUT;
        end else st_nxt = S_TD;
      end
      S_TD: begin
        if (dsq > {18'd0, v_r}) begin
          if (sel_r) st_nxt = S_MUL;
          else if (pb_r < 16'd2) begin
            stat_nxt = ST_NON_PRIME; st_nxt = S_OUT;
          end else begin
            sel_nxt = 1'b1; v_nxt = pb_r; d_nxt = 17'd2;
          end
        end else begin
          req.start = 1'b1; req.dividend = {48'd0, v_r};
          req.divisor = {15'd0, d_r}; st_nxt = S_TDW;
        end
      end
      S_TDW: if (rsp.done) begin
        if (rsp.remainder == '0) begin
          stat_nxt = ST_NON_PRIME; st_nxt = S_OUT;
        end else begin
          d_nxt = d_r + 17'd1; st_nxt = S_TD;
        end
      end
      S_MUL: begin
        mod_nxt = 32'(pa_r) * 32'(pb_r);
        tot_nxt = (32'(pa_r) - 32'd1) * (32'(pb_r) - 32'd1);
        e_nxt = 32'd2; ga_nxt = 32'd2;
        gb_nxt = (32'(pa_r) - 32'd1) * (32'(pb_r) - 32'd1);
        st_nxt = S_GCD;
      end
      S_GCD: begin
        if (gb_r == '0) st_nxt = S_CHK;
        else begin
          req.start = 1'b1; req.dividend = {32'd0, ga_r};
          req.divisor = gb_r; st_nxt = S_GCDW;
        end
      end
      S_GCDW: if (rsp.done) begin
        ga_nxt = gb_r; gb_nxt = rsp.remainder; st_nxt = S_GCD;
      end
      S_CHK: begin
        if (ga_r != 32'd1) begin
          e_nxt = e_r + 32'd1; ga_nxt = e_r + 32'd1; gb_nxt = tot_r; st_nxt = S_GCD;
        end else if (e_r >= tot_r) begin
          stat_nxt = ST_EXP_RANGE; st_nxt = S_OUT;
        end else begin
          k_nxt = 32'd1; st_nxt = S_INV;
        end
      end
      S_INV: begin
        req.start = 1'b1; req.dividend = kt1; req.divisor = e_r; st_nxt = S_INVW;
      end
      S_INVW: if (rsp.done) begin
        if (rsp.remainder == '0 || k_r >= e_r) begin
          pe_nxt = rsp.quotient[WordW-1:0]; stat_nxt = ST_OK; st_nxt = S_OUT;
        end else begin
          k_nxt = k_r + 32'd1; st_nxt = S_INV;
        end
      end
      S_OUT: if (out_tready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= S_IDLE;
    else st_r <= st_nxt;
    pa_r <= pa_nxt; pb_r <= pb_nxt; v_r <= v_nxt; sel_r <= sel_nxt; d_r <= d_nxt;
    mod_r <= mod_nxt; tot_r <= tot_nxt; e_r <= e_nxt; ga_r <= ga_nxt; gb_r <= gb_nxt;
    k_r <= k_nxt; pe_r <= pe_nxt; stat_r <= stat_nxt;
  end

  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = (st_r == S_OUT);
  assign out_tdata  = {6'd0, stat_r, pe_r, e_r, tot_r, mod_r};
endmodule

FILE: tb/sv/tb_top.sv
// Testbench for rsa_key_generation: drives candidate pairs, predicts each key beat.
// Depends on rsakg_pkg and the RTL of the block; self-contained otherwise.
`timescale 1ns / 1ps

module tb_top import rsakg_pkg::*; ();

  typedef struct {
    logic [31:0] modulus;
    logic [31:0] totient;
    logic [31:0] public_exp;
    logic [31:0] private_exp;
    status_t     status;
  } key_t;

  localparam int StallLimit = 200000;

  class key_scoreboard;
    key_t pending_keys[$];
    int   errors;
    int   n_ok, n_non_prime, n_range;

    function bit prime16(int unsigned v);
      int unsigned d;
      if (v < 2) return 0;
      for (d = 2; d * d <= v; d++)
        if (v % d == 0) return 0;
      return 1;
    endfunction

    function longint unsigned gcd(longint unsigned a, longint unsigned b);
      longint unsigned t;
      while (b != 0) begin
        t = a % b;
        a = b;
        b = t;
      end
      return a;
    endfunction

    function void note_pair(logic [15:0] a, logic [15:0] b);
      key_t k;
      longint unsigned tot, e, m;
      k = '{0, 0, 0, 0, ST_OK};
      if (!prime16(a) || !prime16(b)) begin
        k.status = ST_NON_PRIME;
        n_non_prime++;
      end else begin
        tot = longint'(a - 1) * longint'(b - 1);
        e = 2;
        while (gcd(e, tot) != 1) e++;
        k.modulus    = longint'(a) * longint'(b);
        k.totient    = tot;
        k.public_exp = e;
        if (e >= tot) begin
          k.status = ST_EXP_RANGE;
          n_range++;
        end else begin
          // Smallest multiplier that makes m*totient + 1 divisible by e.
          m = 1;
          while (((m * tot) + 1) % e != 0 && m < e) m++;
          k.private_exp = ((m * tot) + 1) / e;
          n_ok++;
        end
      end
      pending_keys = {pending_keys, k};
    endfunction

    function void check_key(logic [135:0] data);
      key_t exp_k;
      if (pending_keys.size() == 0) begin
        $display("%0t: result beat with nothing expected, data %h", $time, data);
        errors++;
        return;
      end
      exp_k = pending_keys.pop_front();
      if (data[31:0] !== exp_k.modulus) begin
        $display("%0t: modulus expected %0d actual %0d", $time, exp_k.modulus, data[31:0]);
        errors++;
      end
      if (data[63:32] !== exp_k.totient) begin
        $display("%0t: totient expected %0d actual %0d", $time, exp_k.totient, data[63:32]);
        errors++;
      end
      if (data[95:64] !== exp_k.public_exp) begin
        $display("%0t: public_exp expected %0d actual %0d", $time, exp_k.public_exp,
                 data[95:64]);
        errors++;
      end
      if (data[127:96] !== exp_k.private_exp) begin
        $display("%0t: private_exp expected %0d actual %0d", $time, exp_k.private_exp,
                 data[127:96]);
        errors++;
      end
      if (data[129:128] !== exp_k.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp_k.status, data[129:128]);
        errors++;
      end
      if (data[135:130] !== 6'd0) begin
        $display("%0t: pad bits expected 0 actual %h", $time, data[135:130]);
        errors++;
      end
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [31:0]  in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [135:0] out_tdata;

  key_scoreboard sb = new();
  int  send_idle_pct, recv_idle_pct;
  bit  long_hold_req;
  int  n_sent, quiet_cycles;

  rsa_key_generation dut (.*);

  always #5 clk = ~clk;

  task automatic send_pair(logic [15:0] a, logic [15:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {b, a};
    do @(posedge clk); while (!in_tready);
    sb.note_pair(a, b);
    n_sent++;
  endtask

  function automatic logic [15:0] small_prime(int unsigned hi);
    logic [15:0] v;
    do v = 16'($urandom_range(hi, 2)); while (!sb.prime16(v));
    return v;
  endfunction

  function automatic logic [15:0] random_candidate();
    int unsigned r;
    r = $urandom_range(99);
    // Mostly small primes so that key beats dominate; full-range values are rare
    // because a large prime costs hundreds of divisions.
    if (r < 65) return small_prime(r < 10 ? 2048 : 256);
    if (r < 88) return 16'($urandom_range(300));
    return 16'($urandom_range(65535));
  endfunction

  // Receiver: random back-pressure plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) sb.check_key(out_tdata);
      if (long_hold_req) begin
        out_tready <= 1'b0;
        repeat (20000) @(posedge clk);
        long_hold_req = 0;
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    logic [15:0] dir_a[$] = '{0, 1, 0, 2, 2, 3, 2, 65521, 65535, 4, 7, 65521, 32749,
                              3, 65535, 1, 97, 251, 65521, 2};
    logic [15:0] dir_b[$] = '{0, 1, 5, 2, 3, 2, 7, 65521, 65535, 7, 4, 3, 2,
                              5, 2, 65521, 89, 241, 0, 65534};
    send_idle_pct = 7;
    recv_idle_pct = 49;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_a[i]) send_pair(dir_a[i], dir_b[i]);

    for (int i = 0; i < 430; i++) begin
      if (i == 140) begin
        send_idle_pct = 49;
        recv_idle_pct = 7;
      end
      if (i == 200) long_hold_req = 1;
      if (i == 290) begin
        // Let the block drain completely before the no-idle phase.
        in_tvalid <= 1'b0;
        wait (sb.pending_keys.size() == 0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      send_pair(random_candidate(), random_candidate());
    end
    in_tvalid <= 1'b0;

    wait (sb.pending_keys.size() == 0);
    repeat (200) @(posedge clk);
    $display("Sent %0d candidate pairs: %0d keys, %0d non-prime, %0d exponent-range.",
             n_sent, sb.n_ok, sb.n_non_prime, sb.n_range);
    if (sb.errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("%0d mismatches found", sb.errors);
      $display("tb_top: FAIL");
    end
    $finish;
  end
endmodule
